/* rtl/ps2kst_pkg.sv */
// Package for the set 1 scan code key state tracker.
// Holds the event codes, the map operation codes, the decode record and
// byte constants. No dependencies.
package ps2kst_pkg;

	localparam int unsigned KEY_SLOTS  = 512;
	localparam int unsigned SLOT_W     = 9;
	localparam int unsigned SKIP_W     = 3;

	// Bytes with a special meaning.
	localparam logic [7:0] BYTE_ACK      = 8'hFA;
	localparam logic [7:0] BYTE_RESEND   = 8'hFE;
	localparam logic [7:0] BYTE_ANNOUNCE = 8'h61;
	localparam logic [7:0] BYTE_PREFIX   = 8'hE0;
	localparam logic [7:0] BYTE_PAUSE    = 8'hE1;
	localparam logic [7:0] BYTE_PRTSC    = 8'h2A;
	localparam logic [7:0] BREAK_BIT     = 8'h80;
	localparam logic [7:0] CODE_PAUSE    = 8'h45;

	localparam logic [SKIP_W-1:0] PAUSE_SKIP = 3'd5;
	localparam logic [SKIP_W-1:0] PRTSC_SKIP = 3'd2;

	// Event kind reported with each result word.
	typedef enum logic [2:0] {
		EV_CONSUMED = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_RELEASED = 3'd2,
		EV_ACK      = 3'd3,
		EV_RESEND   = 3'd4,
		EV_ANNOUNCE = 3'd5
	} event_kind_t;

	// What a word does to the held-key map.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,  // map untouched
		OP_KEY  = 2'd1,  // press or release, decided from the map
		OP_SET  = 2'd2   // fixed press of a special key
	} map_op_t;

	// Outcome of decoding one byte against the control state.
	typedef struct packed {
		event_kind_t         kind;
		map_op_t             op;
		logic [SLOT_W-1:0]   slot;        // own slot of the byte, or the fixed slot
		logic [SKIP_W-1:0]   skip_next;
		logic                prefix_next;
		logic                kbd_next;
	} decode_t;

endpackage

/* rtl/ps2kst_decode.sv */
// Byte decoder of the set 1 key state tracker.
// Classifies one keyboard byte against the skip count, prefix and announce
// state. Depends on ps2kst_pkg.
module ps2kst_decode (
	input  logic [7:0]                   rx_byte,
	input  logic [ps2kst_pkg::SKIP_W-1:0] skip_count,
	input  logic                         prefix_pending,
	input  logic                         kbd_seen,
	output ps2kst_pkg::decode_t          dec
);

	// Priority order: skipping, status bytes, prefixed byte, prefix, pause, plain key.
	always_comb begin
		dec.kind        = ps2kst_pkg::EV_CONSUMED;
		dec.op          = ps2kst_pkg::OP_NONE;
		dec.slot        = '0;
		dec.skip_next   = skip_count;
		dec.prefix_next = prefix_pending;
		dec.kbd_next    = kbd_seen;
		if (skip_count != '0) begin
			dec.skip_next = skip_count - 3'd1;
		end else if (rx_byte == ps2kst_pkg::BYTE_ANNOUNCE) begin
			dec.kbd_next = 1'b1;
			dec.kind     = ps2kst_pkg::EV_ANNOUNCE;
		end else if (rx_byte == ps2kst_pkg::BYTE_ACK) begin
			dec.kind = ps2kst_pkg::EV_ACK;
		end else if (rx_byte == ps2kst_pkg::BYTE_RESEND) begin
			dec.kind = ps2kst_pkg::EV_RESEND;
		end else if (prefix_pending) begin
			dec.prefix_next = 1'b0;
			if (rx_byte == ps2kst_pkg::BYTE_PRTSC) begin
				dec.op        = ps2kst_pkg::OP_SET;
				dec.slot      = {1'b1, ps2kst_pkg::BYTE_PRTSC};
				dec.skip_next = ps2kst_pkg::PRTSC_SKIP;
				dec.kind      = ps2kst_pkg::EV_PRESSED;
			end else begin
				dec.op   = ps2kst_pkg::OP_KEY;
				dec.slot = {1'b1, rx_byte};
			end
		end else if (rx_byte == ps2kst_pkg::BYTE_PREFIX) begin
			dec.prefix_next = 1'b1;
		end else if (rx_byte == ps2kst_pkg::BYTE_PAUSE) begin
			dec.op        = ps2kst_pkg::OP_SET;
			dec.slot      = {1'b1, ps2kst_pkg::CODE_PAUSE};
			dec.skip_next = ps2kst_pkg::PAUSE_SKIP;
			dec.kind      = ps2kst_pkg::EV_PRESSED;
		end else begin
			dec.op   = ps2kst_pkg::OP_KEY;
			dec.slot = {1'b0, rx_byte};
		end
	end

endmodule

/* rtl/ps2_set1_key_state_tracker.sv */
// Top level of the set 1 scan code key state tracker.
// Keeps the 512-slot held-key map in a memory and uses ps2kst_decode and ps2kst_pkg.
//
//   Channel  Dir  Word contents
//   s_*      in   rx_byte, query_key
//   m_*      out  event_kind, key_slot, keyboard_present, query_held
//
// A word is decoded as it is accepted and reads the map (make slot and query slot);
// the reads are registered into stage 1, which resolves press or release, writes the map
// back and loads the output register; one word per cycle while the output is not stalled.
// A write that coincides with the next word's reads is forwarded to it.
// After reset a clearing pass zeroes all 512 map slots; s_tready is low then.
// A stalled output holds stage 1, and input is taken only while stage 1 is empty or moves on.
module ps2_set1_key_state_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] rx_byte, [16:8] query_key, [23:17] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] event_kind, [11:3] key_slot,
	                               // [12] keyboard_present, [13] query_held, [15:14] zero
);

	localparam int unsigned SW = ps2kst_pkg::SLOT_W;

	// Held-key map and its registered read data.
	logic mem_q [ps2kst_pkg::KEY_SLOTS];
	logic rd_make_q;
	logic rd_query_q;

	// Control state.
	logic [ps2kst_pkg::SKIP_W-1:0] skip_q;
	logic                          prefix_q;
	logic                          kbd_q;
	logic                          clearing_q;
	logic [SW-1:0]                 clr_cnt_q;

	// Stage 1.
	logic                    v_s1;
	ps2kst_pkg::map_op_t     op_s1;
	ps2kst_pkg::event_kind_t kind_s1;
	logic [SW-1:0]           slot_s1;
	logic [SW-1:0]           query_s1;
	logic                    kbd_s1;

	// Write forwarded to the word in stage 1.
	logic          fwd_en_q;
	logic [SW-1:0] fwd_addr_q;
	logic          fwd_val_q;

	// Output register.
	logic          out_valid_q;
	logic [15:0]   out_data_q;

	logic                    in_accept;
	logic                    s1_adv;
	ps2kst_pkg::decode_t     dec;
	logic [7:0]              in_byte;
	logic [SW-1:0]           in_query;
	logic [SW-1:0]           in_make;
	logic [SW-1:0]           make_s1;
	logic                    held_make;
	logic                    release_s1;
	logic                    wr_en_s1;
	logic [SW-1:0]           wr_addr_s1;
	logic                    wr_val_s1;
	logic                    q_held_s1;
	logic [SW-1:0]           res_slot_s1;
	ps2kst_pkg::event_kind_t res_kind_s1;
	logic                    mem_we;
	logic [SW-1:0]           mem_wa;
	logic                    mem_wd;

	assign in_byte  = s_tdata[7:0];
	assign in_query = s_tdata[16:8];

	ps2kst_decode u_decode (
		.rx_byte        (in_byte),
		.skip_count     (skip_q),
		.prefix_pending (prefix_q),
		.kbd_seen       (kbd_q),
		.dec            (dec)
	);

	// Handshake: stage 1 moves when the output register is free or being taken.
	assign s1_adv    = !out_valid_q || m_tready;
	assign s_tready  = !clearing_q && (!v_s1 || s1_adv);
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Make-code slot that a break byte would release.
	assign in_make = {dec.slot[8], dec.slot[7:0] - ps2kst_pkg::BREAK_BIT};
	assign make_s1 = {slot_s1[8], slot_s1[7:0] - ps2kst_pkg::BREAK_BIT};

	// Stage 1 resolution of press or release, with forwarding of the last write.
	always_comb begin
		held_make = (fwd_en_q && fwd_addr_q == make_s1) ? fwd_val_q : rd_make_q;
		release_s1 = (op_s1 == ps2kst_pkg::OP_KEY) && (slot_s1[7:0] > ps2kst_pkg::BREAK_BIT)
			&& held_make;
		wr_en_s1   = v_s1 && (op_s1 != ps2kst_pkg::OP_NONE);
		wr_addr_s1 = release_s1 ? make_s1 : slot_s1;
		wr_val_s1  = !release_s1;
		if (wr_en_s1 && query_s1 == wr_addr_s1) begin
			q_held_s1 = wr_val_s1;
		end else if (fwd_en_q && fwd_addr_q == query_s1) begin
			q_held_s1 = fwd_val_q;
		end else begin
			q_held_s1 = rd_query_q;
		end
		case (op_s1)
			ps2kst_pkg::OP_NONE: begin
				res_slot_s1 = '0;
				res_kind_s1 = kind_s1;
			end
			default: begin
				res_slot_s1 = wr_addr_s1;
				res_kind_s1 = release_s1 ? ps2kst_pkg::EV_RELEASED : ps2kst_pkg::EV_PRESSED;
			end
		endcase
	end

	// Memory write port: clearing pass or stage 1 write-back.
	always_comb begin
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = 1'b0;
		end else begin
			mem_we = wr_en_s1 && s1_adv;
			mem_wa = wr_addr_s1;
			mem_wd = wr_val_s1;
		end
	end

	// Held-key map: one write and two registered reads per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (in_accept) begin
			rd_make_q  <= mem_q[in_make];
			rd_query_q <= mem_q[in_query];
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SW'(ps2kst_pkg::KEY_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Control state is updated as each word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q   <= '0;
			prefix_q <= 1'b0;
			kbd_q    <= 1'b0;
		end else if (in_accept) begin
			skip_q   <= dec.skip_next;
			prefix_q <= dec.prefix_next;
			kbd_q    <= dec.kbd_next;
		end
	end

	// Stage 1 valid and forwarding control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fwd_en_q <= 1'b0;
		end else begin
			if (in_accept) begin
				v_s1     <= 1'b1;
				fwd_en_q <= wr_en_s1 && s1_adv;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload and forwarded write data.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1      <= dec.op;
			kind_s1    <= dec.kind;
			slot_s1    <= dec.slot;
			query_s1   <= in_query;
			kbd_s1     <= dec.kbd_next;
			fwd_addr_q <= wr_addr_s1;
			fwd_val_q  <= wr_val_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s1_adv) begin
			out_data_q <= {2'b00, q_held_s1, kbd_s1, res_slot_s1, res_kind_s1};
		end
	end

endmodule
